FILE: rtl/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared constants, character codes and controller/datapath interface types
// for the markup tag tokenizer.
// ----------------------------------------------------------------------------
package mtt_pkg;

  // Token buffer sizing: one slot is kept back, so a token holds at most
  // TOKEN_BYTES-1 bytes.
  localparam int TOKEN_BYTES = 32;
  localparam int STORE_DEPTH = TOKEN_BYTES - 1;
  localparam int LEN_W       = $clog2(TOKEN_BYTES);
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Token type codes on the result channel
  localparam logic [2:0] TT_OPEN       = 3'd0;
  localparam logic [2:0] TT_CLOSE      = 3'd1;
  localparam logic [2:0] TT_TAG_NAME   = 3'd2;
  localparam logic [2:0] TT_ATTR_NAME  = 3'd3;
  localparam logic [2:0] TT_ATTR_VALUE = 3'd4;
  localparam logic [2:0] TT_TEXT       = 3'd5;
  localparam logic [2:0] TT_END        = 3'd6;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       capture;    // latch the request's character
    logic       append;     // write character at the current length
    logic       start;      // write latched character at slot 0, length 1
    logic       rd_clear;   // rewind the read index
    logic       rd_next;    // advance the read index
    logic       len_clear;  // empty the token buffer
    logic       load_out;   // load the output register
    logic       from_ram;   // output byte comes from the token buffer
    logic [2:0] out_type;
    logic [7:0] out_byte;
    logic       out_bval;
    logic       out_last;
  } mtt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic len_zero;   // token buffer is empty
    logic rd_last;    // read index points at the final stored byte
    logic slot_free;  // output register can take a result this cycle
  } mtt_stat_t;

endpackage

FILE: rtl/markup_tag_tokenizer.sv
// ----------------------------------------------------------------------------
// markup_tag_tokenizer
// Streaming markup tokenizer: bytes in, token result bytes out.
// ----------------------------------------------------------------------------
// One request is one markup byte (tuser = 0) or an end of input (tuser = 1,
// or a zero byte). Each token comes out as a run of results sharing one type
// in out_tuser[2:0], closed by tlast; out_tuser[3] flags that out_tdata holds
// a byte (clear for the end token and for an empty attribute value). A byte
// that only extends a token is taken without further steps. A request that
// completes tokens is accepted, then emits each single-byte token from its
// own state, flushes each buffered byte through a read state and an emit
// state (the token buffer's registered read port sets that pace), and stores
// the first byte of a new name or text in a store state. Tokens are buffered
// up to 31 bytes; longer ones lose their tail. The output register lets a new
// request in while a result waits; a stalled result channel delays results.
// ----------------------------------------------------------------------------
module markup_tag_tokenizer
  import mtt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] char_byte
  input  logic       in_tuser,    // [0] kind
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] value_byte
  output logic [3:0] out_tuser,   // [2:0] token_type, [3] byte_valid
  output logic       out_tlast    // last
);

  mtt_cmd_t  dp_cmd;
  mtt_stat_t dp_stat;

  mtt_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .in_char   (in_tdata),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  mtt_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_char    (in_tdata),
    .cmd        (dp_cmd),
    .stat       (dp_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // A result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load_out |-> dp_stat.slot_free)
    else $error("result loaded over a pending result");

  // A buffer flush never reads an empty buffer
  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.load_out && dp_cmd.from_ram) |-> !dp_stat.len_zero)
    else $error("flush from an empty token buffer");

  // Starting a token leaves one byte in the buffer
  a_start_len: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.start |=> !dp_stat.len_zero)
    else $error("token start did not store its byte");

  // No request is taken while the buffer is being flushed
  a_no_accept_flush: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.rd_next |-> !in_tready)
    else $error("request accepted during flush");
`endif

endmodule

FILE: rtl/mtt_ram.sv
// ----------------------------------------------------------------------------
// mtt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mtt_ram #(
  parameter int  WIDTH  = 8,
  parameter int  DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/mtt_datapath.sv
// ----------------------------------------------------------------------------
// mtt_datapath
// Token byte buffer, length and read index counters, and the result
// output register of the markup tag tokenizer.
// ----------------------------------------------------------------------------
module mtt_datapath
  import mtt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_char,
  input  mtt_cmd_t   cmd,
  output mtt_stat_t  stat,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] value_byte
  output logic [3:0] out_tuser,   // [2:0] token_type, [3] byte_valid
  output logic       out_tlast    // last
);

  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [7:0]        char_r;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_type_r;
  logic [7:0]        out_byte_r;
  logic              out_bval_r;
  logic              out_last_r;

  logic              len_full;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic              rd_last;
  logic              slot_free;

  assign len_full  = (len_r == LEN_W'(STORE_DEPTH));
  assign rd_last   = ((LEN_W + 1)'(idx_r) + (LEN_W + 1)'(1)) == (LEN_W + 1)'(len_r);
  assign slot_free = !out_valid_r || out_tready;

  // Buffer write: restart writes slot 0, append writes at the length
  assign ram_we    = (cmd.append && !len_full) || cmd.start;
  assign ram_waddr = cmd.start ? '0 : len_r[ADDR_W-1:0];
  assign ram_wdata = cmd.start ? char_r : in_char;

  mtt_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Length counter; overlong bytes are dropped
  always_comb begin
    len_nxt = len_r;
    priority if (cmd.len_clear) begin
      len_nxt = '0;
    end else if (cmd.start) begin
      len_nxt = LEN_W'(1);
    end else if (cmd.append && !len_full) begin
      len_nxt = len_r + LEN_W'(1);
    end
  end

  // Read index for flushing the buffer
  always_comb begin
    idx_nxt = idx_r;
    priority if (cmd.rd_clear) begin
      idx_nxt = '0;
    end else if (cmd.rd_next) begin
      idx_nxt = idx_r + ADDR_W'(1);
    end
  end

  // Output register valid: hold until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      char_r <= in_char;
    end
    if (cmd.load_out) begin
      out_type_r <= cmd.out_type;
      out_byte_r <= cmd.from_ram ? ram_rdata : cmd.out_byte;
      out_bval_r <= cmd.from_ram ? 1'b1 : cmd.out_bval;
      out_last_r <= cmd.from_ram ? rd_last : cmd.out_last;
    end
  end

  assign stat.len_zero  = (len_r == '0);
  assign stat.rd_last   = rd_last;
  assign stat.slot_free = slot_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_bval_r, out_type_r};
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/mtt_controller.sv
// ----------------------------------------------------------------------------
// mtt_controller
// Scan mode tracking and result sequencing for the markup tag tokenizer.
// Classifies each request byte, then steps the datapath through the results
// it causes: a leading token or a buffer flush, a trailing token, a new token's first byte.
// ----------------------------------------------------------------------------
module mtt_controller
  import mtt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       in_kind,
  input  logic [7:0] in_char,
  input  mtt_stat_t  stat,
  output mtt_cmd_t   cmd
);

  typedef enum logic [5:0] {
    M_IDLE     = 6'b000001,
    M_AFTER_LT = 6'b000010,
    M_AFTER_EQ = 6'b000100,
    M_NAME     = 6'b001000,
    M_QUOTED   = 6'b010000,
    M_TEXT     = 6'b100000
  } scan_mode_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PRE   = 6'b000010,
    S_FRD   = 6'b000100,
    S_FEMIT = 6'b001000,
    S_POST  = 6'b010000,
    S_STORE = 6'b100000
  } seq_state_t;

  typedef struct packed {
    scan_mode_t mode;
    logic       close;
    logic       start;
  } idle_res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_name(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || (c == CH_DASH) ||
           (c == CH_USCORE);
  endfunction

  // Handling of a byte between tokens
  function automatic idle_res_t idle_step(input logic [7:0] c, input logic in_tag);
    idle_res_t r;
    r.mode  = M_IDLE;
    r.close = 1'b0;
    r.start = 1'b0;
    priority if (is_space(c)) begin
      r.mode = M_IDLE;
    end else if (c == CH_LT) begin
      r.mode = M_AFTER_LT;
    end else if (c == CH_GT) begin
      r.close = 1'b1;
    end else if (c == CH_EQ) begin
      r.mode = M_AFTER_EQ;
    end else if (in_tag) begin
      if (is_alpha(c) || c == CH_DASH) begin
        r.start = 1'b1;
        r.mode  = M_NAME;
      end
    end else begin
      r.start = 1'b1;
      r.mode  = M_TEXT;
    end
    return r;
  endfunction

  seq_state_t seq_r, seq_nxt;
  scan_mode_t mode_r, mode_nxt;
  logic       inside_r, inside_nxt;
  logic       dq_r, dq_nxt;
  logic [2:0] pre_type_r;
  logic [7:0] pre_byte_r;
  logic       pre_bval_r;
  logic       post_en_r;
  logic [2:0] post_type_r;
  logic       start_r;

  logic       accept;
  logic       is_end;
  logic       use_idle;
  logic       idle_inside;
  idle_res_t  idle_res;
  logic       dec_single;
  logic       dec_flush;
  logic [2:0] dec_pre_type;
  logic [7:0] dec_pre_byte;
  logic       dec_pre_bval;
  logic       dec_post_en;
  logic [2:0] dec_post_type;
  logic       dec_start;
  logic       dec_append;
  seq_state_t after_pre;

  assign in_tready   = (seq_r == S_IDLE);
  assign accept      = in_tvalid && in_tready;
  assign is_end      = in_kind || (in_char == CH_NUL);
  // A byte right after '<' is handled as inside the tag that it opens
  assign idle_inside = (mode_r == M_AFTER_LT) || inside_r;
  assign idle_res    = idle_step(in_char, idle_inside);

  // Classify the request byte against the current scan mode
  always_comb begin
    mode_nxt      = mode_r;
    inside_nxt    = inside_r;
    dq_nxt        = dq_r;
    dec_single    = 1'b0;
    dec_flush     = 1'b0;
    dec_pre_type  = TT_OPEN;
    dec_pre_byte  = CH_LT;
    dec_pre_bval  = 1'b1;
    dec_post_en   = 1'b0;
    dec_post_type = TT_CLOSE;
    dec_start     = 1'b0;
    dec_append    = 1'b0;
    use_idle      = 1'b0;

    if (is_end) begin
      mode_nxt      = M_IDLE;
      dec_post_en   = 1'b1;
      dec_post_type = TT_END;
      unique case (mode_r)
        M_AFTER_LT: begin
          dec_single = 1'b1;
          inside_nxt = 1'b1;
        end
        M_AFTER_EQ: begin
          dec_single   = 1'b1;
          dec_pre_type = TT_ATTR_VALUE;
          dec_pre_bval = 1'b0;
        end
        M_NAME: begin
          dec_flush    = 1'b1;
          dec_pre_type = TT_TAG_NAME;
        end
        M_QUOTED: begin
          dec_flush    = 1'b1;
          dec_pre_type = TT_ATTR_VALUE;
        end
        M_TEXT: begin
          dec_flush    = 1'b1;
          dec_pre_type = TT_TEXT;
        end
        default: begin
        end
      endcase
    end else begin
      unique case (mode_r)
        M_AFTER_LT: begin
          dec_single = 1'b1;
          if (in_char == CH_SLASH) begin
            mode_nxt     = M_IDLE;
            inside_nxt   = 1'b0;
            dec_pre_type = TT_CLOSE;
            dec_pre_byte = CH_SLASH;
          end else begin
            use_idle = 1'b1;
          end
        end
        M_AFTER_EQ: begin
          if (in_char == CH_DQUOTE || in_char == CH_SQUOTE) begin
            dq_nxt   = (in_char == CH_DQUOTE);
            mode_nxt = M_QUOTED;
          end else begin
            dec_single   = 1'b1;
            dec_pre_type = TT_ATTR_VALUE;
            dec_pre_bval = 1'b0;
            use_idle     = 1'b1;
          end
        end
        M_NAME: begin
          if (is_name(in_char)) begin
            dec_append = 1'b1;
          end else begin
            dec_flush    = 1'b1;
            dec_pre_type = (in_char == CH_EQ) ? TT_ATTR_NAME : TT_TAG_NAME;
            use_idle     = 1'b1;
          end
        end
        M_QUOTED: begin
          if (in_char == (dq_r ? CH_DQUOTE : CH_SQUOTE)) begin
            dec_flush    = 1'b1;
            dec_pre_type = TT_ATTR_VALUE;
            mode_nxt     = M_IDLE;
          end else begin
            dec_append = 1'b1;
          end
        end
        M_TEXT: begin
          if (in_char == CH_LT || in_char == CH_GT) begin
            dec_flush    = 1'b1;
            dec_pre_type = TT_TEXT;
            use_idle     = 1'b1;
          end else begin
            dec_append = 1'b1;
          end
        end
        default: begin
          use_idle = 1'b1;
        end
      endcase

      if (use_idle) begin
        mode_nxt    = idle_res.mode;
        inside_nxt  = idle_res.close ? 1'b0 : idle_inside;
        dec_post_en = idle_res.close;
        dec_start   = idle_res.start;
      end
    end

    // An empty buffer flushes as one empty result
    if (dec_flush && stat.len_zero) begin
      dec_flush    = 1'b0;
      dec_single   = 1'b1;
      dec_pre_bval = 1'b0;
    end
    if (dec_flush || (dec_single && !dec_pre_bval)) begin
      dec_pre_byte = CH_NUL;
    end
  end

  assign after_pre = post_en_r ? S_POST : (start_r ? S_STORE : S_IDLE);

  // Sequence the results and drive datapath commands
  always_comb begin
    seq_nxt      = seq_r;
    cmd          = '0;
    cmd.out_type = pre_type_r;
    cmd.out_byte = pre_byte_r;
    cmd.out_bval = pre_bval_r;
    cmd.out_last = 1'b1;

    unique case (seq_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture  = 1'b1;
          cmd.append   = dec_append;
          cmd.rd_clear = 1'b1;
          priority if (dec_single) begin
            seq_nxt = S_PRE;
          end else if (dec_flush) begin
            seq_nxt = S_FRD;
          end else if (dec_post_en) begin
            seq_nxt = S_POST;
          end else if (dec_start) begin
            seq_nxt = S_STORE;
          end else begin
            seq_nxt = S_IDLE;
          end
        end
      end
      S_PRE: begin
        if (stat.slot_free) begin
          cmd.load_out = 1'b1;
          seq_nxt      = after_pre;
        end
      end
      S_FRD: begin
        seq_nxt = S_FEMIT;
      end
      S_FEMIT: begin
        if (stat.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.from_ram = 1'b1;
          cmd.rd_next  = 1'b1;
          if (stat.rd_last) begin
            cmd.len_clear = 1'b1;
            seq_nxt       = after_pre;
          end else begin
            seq_nxt = S_FRD;
          end
        end
      end
      S_POST: begin
        cmd.out_type = post_type_r;
        cmd.out_byte = (post_type_r == TT_END) ? CH_NUL : CH_GT;
        cmd.out_bval = (post_type_r != TT_END);
        if (stat.slot_free) begin
          cmd.load_out = 1'b1;
          seq_nxt      = start_r ? S_STORE : S_IDLE;
        end
      end
      S_STORE: begin
        cmd.start = 1'b1;
        seq_nxt   = S_IDLE;
      end
      default: begin
        seq_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= S_IDLE;
      mode_r    <= M_IDLE;
      inside_r  <= 1'b0;
      dq_r      <= 1'b0;
      post_en_r <= 1'b0;
      start_r   <= 1'b0;
    end else begin
      seq_r <= seq_nxt;
      if (accept) begin
        mode_r    <= mode_nxt;
        inside_r  <= inside_nxt;
        dq_r      <= dq_nxt;
        post_en_r <= dec_post_en;
        start_r   <= dec_start;
      end
    end
  end

  // Token descriptors for the current request
  always_ff @(posedge clk) begin
    if (accept) begin
      pre_type_r  <= dec_pre_type;
      pre_byte_r  <= dec_pre_byte;
      pre_bval_r  <= dec_pre_bval;
      post_type_r <= dec_post_type;
    end
  end

endmodule
